@@ hdl/tblg_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tblg_pkg
// Shared widths, defaults and controller/datapath interface types for the
// text box line grouper.
// ---------------------------------------------------------------------------
package tblg_pkg;

   localparam int MAX_BOXES_DEF = 64;

   localparam int PIX_W    = 15;  // box coordinates and sizes
   localparam int LSIZE_W  = 16;  // line width and height
   localparam int SCORE_W  = 16;
   localparam int KEY_W    = 17;  // doubled centre
   localparam int NUM_W    = 6;   // line number
   localparam int EMIT_MAX = 64;

   localparam int BOX_W  = 4 * PIX_W + SCORE_W;                 // 76
   localparam int LINE_W = 2 * PIX_W + 2 * LSIZE_W + SCORE_W;   // 78

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 88;

   typedef struct packed {
      logic load;        // take the input beat
      logic clear;       // end of set: zero counts and flag
      logic scan_start;  // selection scan restarts at entry 0
      logic scan_cmp;    // evaluate read entry against best
      logic mode_lines;  // scan runs over lines, else over boxes
      logic rd_match;    // line read address follows the match index
      logic prev_update; // selected key becomes the lower bound
      logic prev_reset;  // no lower bound, rounds restart
      logic match_start;
      logic match_cmp;
      logic new_line;
      logic round_next;
      logic emit_load;
      logic emit_next;
   } cmd_type;

   typedef struct packed {
      logic j_last;
      logic i_last;
      logic k_last;
      logic match;
      logic no_lines;
      logic emit_last;
      logic full;
   } status_type;

endpackage

@@ hdl/text_box_line_grouper.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// text_box_line_grouper
// Groups text boxes into lines by vertical overlap and emits the lines
// top to bottom.
//
// Boxes arrive as req_ beats, one per cycle while loading; tlast marks the
// final box of a set. Up to MAX_BOXES boxes are kept, later ones are dropped
// and flagged in rsp_tuser of every line of the set. After the final beat
// req_tready stays low while the block sorts the N stored boxes by doubled
// centre (one selection scan per box, then match setup), matches each box
// against the L lines built so far and then selects the lines in top order.
// Each store has a single read port. Each line is one rsp_ beat, tlast on
// the last one; a stalled rsp_tready holds the beat and the sequencer waits
// on it. After the last beat is taken the block loads again. Reset empties
// the stores logically and returns to loading.
// ---------------------------------------------------------------------------
module text_box_line_grouper
   import tblg_pkg::*;
#(
   parameter int MAX_BOXES = MAX_BOXES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // box_left[14:0], box_top[29:15], box_width[44:30], box_height[59:45],
   // box_score[75:60], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,   // final_box
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // line_left[14:0], line_top[29:15], line_width[45:30], line_height[61:46],
   // line_score[77:62], line_number[83:78], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,   // final_line
   output logic                  rsp_tuser    // dropped_boxes
);

   cmd_type    cmd;
   status_type status;

   tblg_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tblg_datapath #(.MAX_BOXES(MAX_BOXES)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

   // input and output never overlap within a set
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a line is pending");

   // last line taken returns the block to loading
   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("no return to loading after last line");

   // a final box leaves the loading phase
   a_final_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("grouping did not start on final box");

   // a merge only happens against a stored line
   a_match_has_line: assert property (@(posedge clock) disable iff (reset)
      cmd.match_cmp |-> !status.no_lines)
      else $error("line match without lines");

endmodule

@@ hdl/tblg_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tblg_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ---------------------------------------------------------------------------
module tblg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tblg_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tblg_datapath
// Box and line stores, selection scan, line match/merge and output register.
// ---------------------------------------------------------------------------
module tblg_datapath
   import tblg_pkg::*;
#(
   parameter int MAX_BOXES = MAX_BOXES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);

   localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam int EW = (CW > NUM_W + 1) ? CW : NUM_W + 1;
   localparam int CMP_W = KEY_W + IW;

   logic [CW-1:0]    box_count_ff, box_count_in;
   logic [CW-1:0]    line_count_ff, line_count_in;
   logic             overflow_ff, overflow_in;
   logic [IW-1:0]    j_ff, j_in, i_ff, i_in, k_ff, k_in;
   logic [NUM_W-1:0] out_k_ff, out_k_in;
   logic [CMP_W-1:0] prev_ff, prev_in, best_ff, best_in;
   logic             prev_valid_ff, prev_valid_in, best_found_ff, best_found_in;
   logic [BOX_W-1:0]  bbest_ff, bbest_in;
   logic [LINE_W-1:0] lbest_ff, lbest_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic             out_last_ff, out_last_in, out_drop_ff, out_drop_in;

   logic [BOX_W-1:0]  box_rd;
   logic [LINE_W-1:0] line_rd, line_wr_data, merged, fresh;
   logic              line_we;
   logic [IW-1:0]     line_wr_addr, line_rd_addr;

   // box record: left, top, width, height, score from the low bits up
   logic [PIX_W-1:0]   bl, bt, bw, bh, rt;
   logic [SCORE_W-1:0] bs, ls;
   logic [PIX_W-1:0]   ll, lt;
   logic [LSIZE_W-1:0] lw, lh;
   logic [KEY_W-1:0]   cand_key, cb, cl, diff;
   logic [CMP_W-1:0]   cand;
   logic [LSIZE_W:0]   x1, y1, bx1, by1, lx1, ly1;
   logic [PIX_W-1:0]   nl, nt;
   logic [LSIZE_W-1:0] hmax;
   logic [SCORE_W:0]   ssum;
   logic [CW-1:0]      limit, lim_m1, box_m1, line_m1;
   logic [EW-1:0]      out_k_p1;

   tblg_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_box_ram (
      .clock   (clock),
      .wr_en   (cmd.load && !status.full),
      .wr_addr (box_count_ff[IW-1:0]),
      .wr_data (req_tdata[BOX_W-1:0]),
      .rd_addr (j_ff),
      .rd_data (box_rd)
   );

   tblg_ram #(.WIDTH(LINE_W), .DEPTH(MAX_BOXES)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_wr_addr),
      .wr_data (line_wr_data),
      .rd_addr (line_rd_addr),
      .rd_data (line_rd)
   );

   always_comb begin
      bl = bbest_ff[PIX_W-1:0];
      bt = bbest_ff[2*PIX_W-1:PIX_W];
      bw = bbest_ff[3*PIX_W-1:2*PIX_W];
      bh = bbest_ff[4*PIX_W-1:3*PIX_W];
      bs = bbest_ff[BOX_W-1:4*PIX_W];
      ll = line_rd[PIX_W-1:0];
      lt = line_rd[2*PIX_W-1:PIX_W];
      lw = line_rd[2*PIX_W+LSIZE_W-1:2*PIX_W];
      lh = line_rd[2*PIX_W+2*LSIZE_W-1:2*PIX_W+LSIZE_W];
      ls = line_rd[LINE_W-1:2*PIX_W+2*LSIZE_W];
      rt = box_rd[2*PIX_W-1:PIX_W];

      cb   = {1'b0, bt, 1'b0} + KEY_W'(bh);
      cl   = {1'b0, lt, 1'b0} + KEY_W'(lh);
      diff = (cb > cl) ? cb - cl : cl - cb;
      hmax = (lh > LSIZE_W'(bh)) ? lh : LSIZE_W'(bh);

      lx1 = (LSIZE_W+1)'(ll) + (LSIZE_W+1)'(lw);
      bx1 = (LSIZE_W+1)'(bl) + (LSIZE_W+1)'(bw);
      ly1 = (LSIZE_W+1)'(lt) + (LSIZE_W+1)'(lh);
      by1 = (LSIZE_W+1)'(bt) + (LSIZE_W+1)'(bh);
      x1  = (lx1 > bx1) ? lx1 : bx1;
      y1  = (ly1 > by1) ? ly1 : by1;
      nl  = (ll < bl) ? ll : bl;
      nt  = (lt < bt) ? lt : bt;
      ssum = (SCORE_W+1)'(ls) + (SCORE_W+1)'(bs);
      merged = {ssum[SCORE_W:1],
                LSIZE_W'(y1 - (LSIZE_W+1)'(nt)),
                LSIZE_W'(x1 - (LSIZE_W+1)'(nl)), nt, nl};
      fresh  = {bs, 1'b0, bh, 1'b0, bw, bt, bl};

      cand_key = cmd.mode_lines ? KEY_W'(lt) : ({1'b0, rt, 1'b0} + KEY_W'(box_rd[4*PIX_W-1:3*PIX_W]));
      cand     = {cand_key, j_ff};

      limit   = cmd.mode_lines ? line_count_ff : box_count_ff;
      lim_m1  = limit - CW'(1);
      box_m1  = box_count_ff - CW'(1);
      line_m1 = line_count_ff - CW'(1);
      out_k_p1 = EW'(out_k_ff) + EW'(1);

      status.j_last    = (j_ff == lim_m1[IW-1:0]);
      status.i_last    = (i_ff == line_m1[IW-1:0]);
      status.k_last    = (k_ff == box_m1[IW-1:0]);
      status.match     = (diff <= KEY_W'(hmax));
      status.no_lines  = (line_count_ff == '0);
      status.emit_last = (out_k_ff == NUM_W'(EMIT_MAX - 1)) || (out_k_p1 == EW'(line_count_ff));
      status.full      = (box_count_ff == CW'(MAX_BOXES));

      // rd_addr follows the match index only while lines are matched
      line_rd_addr = cmd.rd_match ? i_ff : j_ff;
      line_we      = (cmd.match_cmp && (status.match || status.i_last)) || cmd.new_line;
      line_wr_addr = (cmd.match_cmp && status.match) ? i_ff : line_count_ff[IW-1:0];
      line_wr_data = (cmd.match_cmp && status.match) ? merged : fresh;
   end

   always_comb begin
      box_count_in  = box_count_ff;
      line_count_in = line_count_ff;
      overflow_in   = overflow_ff;
      j_in = j_ff; i_in = i_ff; k_in = k_ff; out_k_in = out_k_ff;
      prev_in = prev_ff; prev_valid_in = prev_valid_ff;
      best_in = best_ff; best_found_in = best_found_ff;
      bbest_in = bbest_ff; lbest_in = lbest_ff;
      out_data_in = out_data_ff; out_last_in = out_last_ff; out_drop_in = out_drop_ff;

      if (cmd.load) begin
         if (status.full) overflow_in = 1'b1;
         else box_count_in = box_count_ff + CW'(1);
      end
      if (cmd.scan_start) begin
         j_in = '0;
         best_found_in = 1'b0;
      end
      if (cmd.scan_cmp) begin
         if ((!prev_valid_ff || cand > prev_ff) && (!best_found_ff || cand < best_ff)) begin
            best_in       = cand;
            best_found_in = 1'b1;
            if (cmd.mode_lines) lbest_in = line_rd;
            else bbest_in = box_rd;
         end
         j_in = j_ff + IW'(1);
      end
      if (cmd.prev_update) begin
         prev_in       = best_ff;
         prev_valid_in = 1'b1;
      end
      if (cmd.prev_reset) begin
         prev_valid_in = 1'b0;
         k_in          = '0;
         out_k_in      = '0;
      end
      if (cmd.round_next) k_in = k_ff + IW'(1);
      if (cmd.match_start) i_in = '0;
      if (cmd.match_cmp) begin
         if (!status.match) begin
            if (status.i_last) line_count_in = line_count_ff + CW'(1);
            else i_in = i_ff + IW'(1);
         end
      end
      if (cmd.new_line) line_count_in = line_count_ff + CW'(1);
      if (cmd.emit_load) begin
         out_data_in = {4'b0, out_k_ff, lbest_ff};
         out_last_in = status.emit_last;
         out_drop_in = overflow_ff;
      end
      if (cmd.emit_next) out_k_in = out_k_ff + NUM_W'(1);
      if (cmd.clear) begin
         box_count_in  = '0;
         line_count_in = '0;
         overflow_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_count_ff  <= '0;
         line_count_ff <= '0;
         overflow_ff   <= 1'b0;
         prev_valid_ff <= 1'b0;
         best_found_ff <= 1'b0;
         j_ff <= '0; i_ff <= '0; k_ff <= '0; out_k_ff <= '0;
      end else begin
         box_count_ff  <= box_count_in;
         line_count_ff <= line_count_in;
         overflow_ff   <= overflow_in;
         prev_valid_ff <= prev_valid_in;
         best_found_ff <= best_found_in;
         j_ff <= j_in; i_ff <= i_in; k_ff <= k_in; out_k_ff <= out_k_in;
      end
      prev_ff     <= prev_in;
      best_ff     <= best_in;
      bbest_ff    <= bbest_in;
      lbest_ff    <= lbest_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_drop_ff <= out_drop_in;
   end

   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;
   assign rsp_tuser = out_drop_ff;

endmodule

@@ hdl/tblg_controller.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tblg_controller
// Sequencer for load, box sort, line match and ordered line emission.
// ---------------------------------------------------------------------------
module tblg_controller
   import tblg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_LOAD, S_SEL_START, S_SEL_RD, S_SEL_CMP, S_MATCH_START, S_NEW,
      S_MATCH_RD, S_MATCH_CMP, S_NEXT, S_ORD_START, S_ORD_RD, S_ORD_CMP,
      S_EMIT_LOAD, S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_tlast) begin
                  cmd.prev_reset = 1'b1;
                  state_in       = S_SEL_START;
               end
            end
         end
         S_SEL_START: begin
            cmd.scan_start = 1'b1;
            state_in       = S_SEL_RD;
         end
         S_SEL_RD: state_in = S_SEL_CMP;
         S_SEL_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = status.j_last ? S_MATCH_START : S_SEL_RD;
         end
         S_MATCH_START: begin
            cmd.match_start = 1'b1;
            state_in        = status.no_lines ? S_NEW : S_MATCH_RD;
         end
         S_NEW: begin
            cmd.new_line = 1'b1;
            state_in     = S_NEXT;
         end
         S_MATCH_RD: begin
            cmd.rd_match = 1'b1;
            state_in     = S_MATCH_CMP;
         end
         S_MATCH_CMP: begin
            cmd.match_cmp = 1'b1;
            state_in      = (status.match || status.i_last) ? S_NEXT : S_MATCH_RD;
         end
         S_NEXT: begin
            if (status.k_last) begin
               cmd.prev_reset = 1'b1;
               state_in       = S_ORD_START;
            end else begin
               cmd.prev_update = 1'b1;
               cmd.round_next  = 1'b1;
               state_in        = S_SEL_START;
            end
         end
         S_ORD_START: begin
            cmd.scan_start = 1'b1;
            cmd.mode_lines = 1'b1;
            state_in       = S_ORD_RD;
         end
         S_ORD_RD: begin
            cmd.mode_lines = 1'b1;
            state_in       = S_ORD_CMP;
         end
         S_ORD_CMP: begin
            cmd.scan_cmp   = 1'b1;
            cmd.mode_lines = 1'b1;
            state_in       = status.j_last ? S_EMIT_LOAD : S_ORD_RD;
         end
         S_EMIT_LOAD: begin
            cmd.emit_load = 1'b1;
            rsp_valid_in  = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (status.emit_last) begin
                  cmd.clear = 1'b1;
                  state_in  = S_LOAD;
               end else begin
                  cmd.emit_next   = 1'b1;
                  cmd.prev_update = 1'b1;
                  state_in        = S_ORD_START;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_LOAD);
   assign rsp_tvalid = rsp_valid_ff;

endmodule
